// ----- src/ffs_pkg.sv -----
`timescale 1ns / 1ps
package ffs_pkg;

    localparam int LENGTH_BITS_DEF = 24;

    localparam int STEP_W    = 4;
    localparam int OP_W      = 4;
    localparam int COND_W    = 4;
    localparam int DIV_IDX_W = 3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_GROW   = 4'd2;
    localparam logic [OP_W-1:0] OP_LDV    = 4'd3;
    localparam logic [OP_W-1:0] OP_HALF   = 4'd4;
    localparam logic [OP_W-1:0] OP_DSTART = 4'd5;
    localparam logic [OP_W-1:0] OP_DSTEP  = 4'd6;
    localparam logic [OP_W-1:0] OP_TAKEQ  = 4'd7;
    localparam logic [OP_W-1:0] OP_NEXTM  = 4'd8;
    localparam logic [OP_W-1:0] OP_NEXTD  = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

    // jump conditions
    localparam logic [COND_W-1:0] C_ALWAYS    = 4'd0;
    localparam logic [COND_W-1:0] C_IDLE      = 4'd1;
    localparam logic [COND_W-1:0] C_TOP_LT_N  = 4'd2;
    localparam logic [COND_W-1:0] C_M_GE_TOP  = 4'd3;
    localparam logic [COND_W-1:0] C_V_EVEN    = 4'd4;
    localparam logic [COND_W-1:0] C_CNT_MORE  = 4'd5;
    localparam logic [COND_W-1:0] C_REM_NZ    = 4'd6;
    localparam logic [COND_W-1:0] C_SMALL_DIV = 4'd7;
    localparam logic [COND_W-1:0] C_V_ONE     = 4'd8;
    localparam logic [COND_W-1:0] C_LAST_DIV  = 4'd9;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd10;
    localparam logic [COND_W-1:0] C_NEVER     = 4'd11;

    // program steps
    localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] S_GROW   = 4'd1;
    localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
    localparam logic [STEP_W-1:0] S_HALF   = 4'd3;
    localparam logic [STEP_W-1:0] S_DSTART = 4'd4;
    localparam logic [STEP_W-1:0] S_DSTEP  = 4'd5;
    localparam logic [STEP_W-1:0] S_DCHK   = 4'd6;
    localparam logic [STEP_W-1:0] S_DIVD   = 4'd7;
    localparam logic [STEP_W-1:0] S_FINAL  = 4'd8;
    localparam logic [STEP_W-1:0] S_NEXTM  = 4'd9;
    localparam logic [STEP_W-1:0] S_NDIV   = 4'd10;
    localparam logic [STEP_W-1:0] S_RETRY  = 4'd11;
    localparam logic [STEP_W-1:0] S_EMIT   = 4'd12;
    localparam logic [STEP_W-1:0] S_WRAP   = 4'd13;

    // divisor table index: 3, 5, 7 are stripped fully, 11 or 13 once
    localparam logic [DIV_IDX_W-1:0] DIV_FIRST     = 3'd0;
    localparam logic [DIV_IDX_W-1:0] DIV_ONCE_FIRST = 3'd3;
    localparam logic [DIV_IDX_W-1:0] DIV_LAST      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    typedef struct packed {
        logic more;
        logic rem_zero;
    } div_stat_t;

    function automatic logic [3:0] divisor(input logic [DIV_IDX_W-1:0] idx);
        logic [3:0] d;
        case (idx)
            3'd0:    d = 4'd3;
            3'd1:    d = 4'd5;
            3'd2:    d = 4'd7;
            3'd3:    d = 4'd11;
            default: d = 4'd13;
        endcase
        return d;
    endfunction

    // one radix-16 digit of long division: returns {quotient digit, remainder}
    function automatic logic [7:0] div_nibble(input logic [3:0] rem, input logic [3:0] dig,
                                              input logic [3:0] d);
        logic [4:0] r;
        logic [3:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = 3; i >= 0; i--) begin
            r = {r[3:0], dig[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return {q, r[3:0]};
    endfunction

    // control store: next step is target when cond holds, else step + 1
    function automatic uword_t ucode(input logic [STEP_W-1:0] s);
        uword_t w;
        case (s)
            S_WAIT:   w = '{OP_LOAD,   C_IDLE,      S_WAIT};
            S_GROW:   w = '{OP_GROW,   C_TOP_LT_N,  S_GROW};
            S_CHECK:  w = '{OP_LDV,    C_M_GE_TOP,  S_EMIT};
            S_HALF:   w = '{OP_HALF,   C_V_EVEN,    S_HALF};
            S_DSTART: w = '{OP_DSTART, C_NEVER,     S_DSTART};
            S_DSTEP:  w = '{OP_DSTEP,  C_CNT_MORE,  S_DSTEP};
            S_DCHK:   w = '{OP_NOP,    C_REM_NZ,    S_NDIV};
            S_DIVD:   w = '{OP_TAKEQ,  C_SMALL_DIV, S_DSTART};
            S_FINAL:  w = '{OP_NOP,    C_V_ONE,     S_EMIT};
            S_NEXTM:  w = '{OP_NEXTM,  C_ALWAYS,    S_CHECK};
            S_NDIV:   w = '{OP_NEXTD,  C_LAST_DIV,  S_FINAL};
            S_RETRY:  w = '{OP_NOP,    C_ALWAYS,    S_DSTART};
            S_EMIT:   w = '{OP_EMIT,   C_OUT_BUSY,  S_EMIT};
            S_WRAP:   w = '{OP_NOP,    C_ALWAYS,    S_WAIT};
            default:  w = '{OP_NOP,    C_ALWAYS,    S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/fft_friendly_size_search.sv -----
// Sequence: after an input transfer the power-of-two bound doubles until it is at least n; each
//   candidate from n upward has its factors of 2 halved out, then is divided by 3, 5 and 7 fully
//   and by 11 or 13 once; the first candidate left at 1, or else the bound, goes to m_axis_tdata.
// Throughput: one request at a time; s_axis_tready returns via the wrap step after the result registers.
// Reset (aresetn low, synchronous) returns the sequencer to its wait step and drops m_axis_tvalid.
`timescale 1ns / 1ps
module fft_friendly_size_search #(
    parameter int  LENGTH_BITS = ffs_pkg::LENGTH_BITS_DEF,
    localparam int LW          = LENGTH_BITS + 1,
    localparam int TW          = ((LENGTH_BITS + 8) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [TW-1:0] s_axis_tdata,   // [LW-1:0] requested_length
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [TW-1:0] m_axis_tdata    // [LW-1:0] good_length
);
    import ffs_pkg::*;

    logic [STEP_W-1:0]    step_reg, step_next;
    logic [LW-1:0]        n_reg, n_next;
    logic [LW-1:0]        m_reg, m_next;
    logic [LW-1:0]        top_reg, top_next;
    logic [LW-1:0]        v_reg, v_next;
    logic [DIV_IDX_W-1:0] didx_reg, didx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LW-1:0]        out_data_reg, out_data_next;

    uword_t               uw;
    logic                 jump;
    logic                 in_xfer;
    logic                 out_busy;
    logic [LW-1:0]        n_in, n_clamp, len_max, quotient;
    div_ctrl_t            dctrl;
    div_stat_t            dstat;

    assign uw       = ucode(step_reg);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_busy = out_valid_reg && !m_axis_tready;
    assign n_in     = s_axis_tdata[LW-1:0];
    assign len_max  = LW'(1) << LENGTH_BITS;

    always_comb begin
        if (n_in <= LW'(1)) begin
            n_clamp = LW'(1);
        end else if (n_in > len_max) begin
            n_clamp = len_max;
        end else begin
            n_clamp = n_in;
        end
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    jump = 1'b1;
            C_IDLE:      jump = !s_axis_tvalid;
            C_TOP_LT_N:  jump = (top_reg < n_reg);
            C_M_GE_TOP:  jump = (m_reg >= top_reg);
            C_V_EVEN:    jump = !v_reg[0];
            C_CNT_MORE:  jump = dstat.more;
            C_REM_NZ:    jump = !dstat.rem_zero;
            C_SMALL_DIV: jump = (didx_reg < DIV_ONCE_FIRST);
            C_V_ONE:     jump = (v_reg == LW'(1));
            C_LAST_DIV:  jump = (didx_reg == DIV_LAST);
            C_OUT_BUSY:  jump = out_busy;
            default:     jump = 1'b0;
        endcase
    end

    assign step_next = jump ? uw.target : step_reg + STEP_W'(1);

    always_comb begin
        n_next         = n_reg;
        m_next         = m_reg;
        top_next       = top_reg;
        v_next         = v_reg;
        didx_next      = didx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        dctrl          = '0;
        case (uw.op)
            OP_LOAD: begin
                if (in_xfer) begin
                    n_next   = n_clamp;
                    m_next   = n_clamp;
                    top_next = LW'(1);
                end
            end
            OP_GROW: begin
                if (top_reg < n_reg) begin
                    top_next = {top_reg[LW-2:0], 1'b0};
                end
            end
            OP_LDV: begin
                v_next    = m_reg;
                didx_next = DIV_FIRST;
            end
            OP_HALF: begin
                if (!v_reg[0]) begin
                    v_next = {1'b0, v_reg[LW-1:1]};
                end
            end
            OP_DSTART: dctrl.start = 1'b1;
            OP_DSTEP:  dctrl.step  = 1'b1;
            OP_TAKEQ:  v_next      = quotient;
            OP_NEXTM:  m_next      = m_reg + LW'(1);
            OP_NEXTD:  didx_next   = didx_reg + DIV_IDX_W'(1);
            OP_EMIT: begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    out_data_next  = m_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= S_WAIT;
            out_valid_reg <= 1'b0;
            m_reg         <= LW'(1);
            top_reg       <= LW'(1);
            didx_reg      <= DIV_FIRST;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            m_reg         <= m_next;
            top_reg       <= top_next;
            didx_reg      <= didx_next;
        end
        n_reg        <= n_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
    end

    ffs_nibble_div #(
        .LW(LW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (dctrl),
        .divisor_val (divisor(didx_reg)),
        .value       (v_reg),
        .quotient    (quotient),
        .stat        (dstat)
    );

    assign s_axis_tready = (step_reg == S_WAIT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TW'(out_data_reg);

`ifndef NO_ASSERTIONS
    a_top_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(top_reg))
        else $error("search bound is not a power of two");

    a_cand_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == S_CHECK) |-> (m_reg <= top_reg))
        else $error("candidate passed the power-of-two bound");

    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> ($past(step_reg) == S_EMIT))
        else $error("result raised outside the emit step");

    a_div_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == S_DSTEP) |-> (didx_reg <= DIV_LAST))
        else $error("divisor index out of range during division");
`endif

endmodule

// ----- src/ffs_nibble_div.sv -----
`timescale 1ns / 1ps
module ffs_nibble_div #(
    parameter int LW = ffs_pkg::LENGTH_BITS_DEF + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffs_pkg::div_ctrl_t ctrl,
    input  logic [3:0]        divisor_val,
    input  logic [LW-1:0]     value,
    output logic [LW-1:0]     quotient,
    output ffs_pkg::div_stat_t stat
);
    import ffs_pkg::*;

    localparam int NDIG = (LW + 3) / 4;
    localparam int DW   = NDIG * 4;
    localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [DW-1:0] sh_reg, sh_next;
    logic [LW-1:0] q_reg, q_next;
    logic [3:0]    r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    dig_res;

    assign dig_res = div_nibble(r_reg, sh_reg[DW-1 -: 4], divisor_val);

    always_comb begin
        sh_next  = sh_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        if (ctrl.start) begin
            sh_next  = DW'(value);
            q_next   = '0;
            r_next   = '0;
            cnt_next = '0;
        end else if (ctrl.step) begin
            sh_next  = {sh_reg[DW-5:0], 4'b0000};
            q_next   = {q_reg[LW-5:0], dig_res[7:4]};
            r_next   = dig_res[3:0];
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        sh_reg <= sh_next;
        q_reg  <= q_next;
        r_reg  <= r_next;
    end

    assign quotient      = q_reg;
    assign stat.more     = (cnt_reg != CW'(NDIG - 1));
    assign stat.rem_zero = (r_reg == 4'd0);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

    localparam int LEN_BITS = ffs_pkg::LENGTH_BITS_DEF;
    localparam int LW       = LEN_BITS + 1;
    localparam int TW       = ((LEN_BITS + 8) / 8) * 8;

    localparam longint unsigned LEN_CAP  = 64'd1 << LEN_BITS;
    localparam longint unsigned FIELD_MAX = (64'd1 << LW) - 1;

    localparam int STALL_MAX      = 17;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct {
        logic [LW-1:0] request;
        logic [LW-1:0] size;
    } pending_t;

    logic          aclk          = 1'b0;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [TW-1:0] s_axis_tdata  = '0;   // [LW-1:0] requested_length
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [TW-1:0] m_axis_tdata;         // [LW-1:0] good_length

    pending_t pending_sizes[$];
    pending_t head;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int items_sent      = 0;
    int results_checked = 0;
    int errors          = 0;
    int quiet_cycles    = 0;

    fft_friendly_size_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_fft_friendly(input longint unsigned v);
        longint unsigned r;
        r = v;
        if (r == 0) begin
            return 1'b0;
        end
        while (r % 2 == 0) r = r / 2;
        while (r % 3 == 0) r = r / 3;
        while (r % 5 == 0) r = r / 5;
        while (r % 7 == 0) r = r / 7;
        // at most one of 11 or 13, with 11 taking priority
        if (r % 11 == 0) begin
            r = r / 11;
        end else if (r % 13 == 0) begin
            r = r / 13;
        end
        return r == 1;
    endfunction

    function automatic logic [LW-1:0] fft_size_for(input logic [LW-1:0] n);
        longint unsigned want;
        longint unsigned top;
        longint unsigned m;
        want = n;
        if (want <= 1) begin
            return LW'(1);
        end
        if (want > LEN_CAP) begin
            want = LEN_CAP;
        end
        top = 1;
        while (top < want) top = top << 1;
        for (m = want; m < top; m++) begin
            if (is_fft_friendly(m)) begin
                return LW'(m);
            end
        end
        return LW'(top);
    endfunction

    task automatic set_idling(input bit src_on, input bit sink_on);
        src_idle_on  = src_on;
        sink_idle_on = sink_on;
    endtask

    task automatic send_length(input logic [LW-1:0] n);
        int gap;
        pending_t p;
        gap = src_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TW'(n);
        do @(posedge aclk); while (!s_axis_tready);
        p.request = n;
        p.size    = fft_size_for(n);
        pending_sizes.insert(pending_sizes.size(), p);
        items_sent++;
    endtask

    task automatic test_edge_lengths();
        set_idling(1'b1, 1'b1);
        send_length(LW'(0));
        send_length(LW'(1));
        send_length(LW'(2));
        send_length(LW'(3));
        send_length(LW'(5));
        send_length(LW'(LEN_CAP));
        send_length(LW'(LEN_CAP - 1));
        send_length(LW'(LEN_CAP + 1));
        send_length(LW'(FIELD_MAX));
        send_length(LW'(14348907));     // 3^15
        send_length(LW'(14348906));
    endtask

    task automatic test_factor_cases();
        set_idling(1'b0, 1'b0);
        send_length(LW'(701));          // lands on 2*27*13
        send_length(LW'(703));          // lands on 64*11
        send_length(LW'(143));          // 11*13 is rejected
        send_length(LW'(1001));
        send_length(LW'(1144));
        send_length(LW'(121));          // 11 squared is rejected
        send_length(LW'(169));          // 13 squared is rejected
        send_length(LW'(11 * (1 << 20)));
        send_length(LW'(13 * (1 << 20)));
        send_length(LW'(11 * 2187));
        send_length(LW'(13 * 15625));
    endtask

    task automatic test_near_powers(input int count);
        int k;
        longint unsigned p2;
        longint unsigned off;
        set_idling(1'b1, 1'b1);
        repeat (count) begin
            k   = $urandom_range(1, LEN_BITS);
            p2  = 64'd1 << k;
            off = $urandom_range(0, 24);
            if (off >= p2) begin
                off = p2 - 1;
            end
            send_length(LW'(p2 - off));
        end
    endtask

    task automatic test_near_smooth(input int count);
        longint unsigned m;
        longint unsigned off;
        int picks;
        int p;
        for (int i = 0; i < count; i++) begin
            set_idling(i < count / 2, i % 3 != 0);
            case ($urandom_range(0, 2))
                1:       m = 11;
                2:       m = 13;
                default: m = 1;
            endcase
            picks = $urandom_range(0, 30);
            repeat (picks) begin
                case ($urandom_range(0, 3))
                    0:       p = 2;
                    1:       p = 3;
                    2:       p = 5;
                    default: p = 7;
                endcase
                if (m * p <= LEN_CAP) begin
                    m = m * p;
                end
            end
            off = $urandom_range(0, 16);
            if (off >= m) begin
                off = m - 1;
            end
            send_length(LW'(m - off));
        end
    endtask

    task automatic test_small_lengths(input int count);
        for (int i = 0; i < count; i++) begin
            set_idling(i >= count / 3, i < 2 * count / 3);
            if ($urandom_range(0, 3) == 0) begin
                send_length(LW'($urandom_range(1, 16)));
            end else begin
                send_length(LW'($urandom_range(1, 4096)));
            end
        end
    endtask

    task automatic test_saturated_lengths(input int count);
        set_idling(1'b0, 1'b1);
        send_length(LW'(0));
        repeat (count) begin
            send_length(LW'($urandom_range(32'(LEN_CAP + 1), 32'(FIELD_MAX))));
        end
    endtask

    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_sizes.size() == 0) begin
                $display("%0t: unexpected result transfer, got %0d", $time, m_axis_tdata);
                errors++;
            end else begin
                head = pending_sizes.pop_front();
                if (m_axis_tdata !== TW'(head.size)) begin
                    $display("%0t: good_length mismatch for n=%0d: expected %0d, actual %0d",
                             $time, head.request, head.size, m_axis_tdata);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_sizes.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_lengths();
        test_factor_cases();
        test_near_powers(80);
        test_near_smooth(160);
        test_small_lengths(120);
        test_saturated_lengths(20);

        s_axis_tvalid <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d length requests: edges, 11/13 factors, near powers of two,",
                 items_sent);
        $display("near smooth sizes, small and saturated lengths; %0d results checked, %0d errors",
                 results_checked, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
